// File: sv/stlb_pkg.sv
// ----------------------------------------------------------------------------
// stlb_pkg
// Shared types and constants for the segment TLB refill block.
// ----------------------------------------------------------------------------
`default_nettype none

package stlb_pkg;

  // page geometry
  localparam int unsigned PAGE_SHIFT = 12;
  localparam int unsigned ADDR_W     = 32;
  localparam int unsigned PAGE_NUM_W = ADDR_W - PAGE_SHIFT;
  localparam int unsigned COUNT_W    = 20;
  localparam int unsigned SLOT_IDX_W = 6;

  // entry_low flag bits
  localparam int unsigned ENTRY_DIRTY_BIT = 10;
  localparam int unsigned ENTRY_VALID_BIT = 9;

  // defaults for the top level parameters
  localparam int unsigned        DEF_TLB_SLOTS   = 64;
  localparam int unsigned        DEF_STACK_PAGES = 12;
  localparam logic [ADDR_W-1:0]  DEF_STACK_TOP   = 32'h8000_0000;

  typedef enum logic {
    OP_MISS  = 1'b0,
    OP_FLUSH = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    KIND_READ     = 2'd0,
    KIND_WRITE    = 2'd1,
    KIND_READONLY = 2'd2,
    KIND_UNKNOWN  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_DONE     = 2'd0,
    ST_FAULT    = 2'd1,
    ST_BAD_KIND = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    CFG_TEXT_VBASE  = 3'd0,
    CFG_TEXT_PBASE  = 3'd1,
    CFG_TEXT_PAGES  = 3'd2,
    CFG_DATA_VBASE  = 3'd3,
    CFG_DATA_PBASE  = 3'd4,
    CFG_DATA_PAGES  = 3'd5,
    CFG_STACK_PBASE = 3'd6,
    CFG_TEXT_WP     = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic [ADDR_W-1:0]  text_vbase;
    logic [ADDR_W-1:0]  text_pbase;
    logic [COUNT_W-1:0] text_pages;
    logic [ADDR_W-1:0]  data_vbase;
    logic [ADDR_W-1:0]  data_pbase;
    logic [COUNT_W-1:0] data_pages;
    logic [ADDR_W-1:0]  stack_pbase;
    logic               text_wp;
  } cfg_regs_t;

  typedef struct packed {
    logic              operation;
    logic [1:0]        fault_kind;
    logic [ADDR_W-1:0] fault_address;
    logic              space_present;
  } in_item_t;

  typedef struct packed {
    status_t           status;
    logic              install;
    logic              flush;
    logic [ADDR_W-1:0] entry_high;
    logic [ADDR_W-1:0] entry_low;
  } xlate_res_t;

  typedef struct packed {
    logic fire;
    logic install;
    logic flush;
  } slot_req_t;

  typedef struct packed {
    logic [SLOT_IDX_W-1:0] slot;
    logic                  by_pointer;
  } slot_grant_t;

endpackage

`default_nettype wire

// File: sv/stlb_cfg.sv
// ----------------------------------------------------------------------------
// stlb_cfg
// Configuration register file for the region bases, sizes and text protect.
// ----------------------------------------------------------------------------
`default_nettype none

module stlb_cfg (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      cfg_valid,
  input  wire logic [2:0]                cfg_index,
  input  wire logic [stlb_pkg::ADDR_W-1:0] cfg_data,
  output stlb_pkg::cfg_regs_t            regs
);
  import stlb_pkg::*;

  cfg_regs_t regs_r;
  cfg_regs_t regs_nxt;

  always_comb begin
    regs_nxt = regs_r;
    if (cfg_valid) begin
      case (cfg_idx_t'(cfg_index))
        CFG_TEXT_VBASE:  regs_nxt.text_vbase  = cfg_data;
        CFG_TEXT_PBASE:  regs_nxt.text_pbase  = cfg_data;
        CFG_TEXT_PAGES:  regs_nxt.text_pages  = cfg_data[COUNT_W-1:0];
        CFG_DATA_VBASE:  regs_nxt.data_vbase  = cfg_data;
        CFG_DATA_PBASE:  regs_nxt.data_pbase  = cfg_data;
        CFG_DATA_PAGES:  regs_nxt.data_pages  = cfg_data[COUNT_W-1:0];
        CFG_STACK_PBASE: regs_nxt.stack_pbase = cfg_data;
        CFG_TEXT_WP:     regs_nxt.text_wp     = cfg_data[0];
        default:         regs_nxt = regs_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r <= '0;
    end else begin
      regs_r <= regs_nxt;
    end
  end

  assign regs = regs_r;

endmodule

`default_nettype wire

// File: sv/stlb_xlate.sv
// ----------------------------------------------------------------------------
// stlb_xlate
// Kind checks, three-region lookup and TLB entry formation for one miss, or a flush.
// ----------------------------------------------------------------------------
`default_nettype none

module stlb_xlate #(
  parameter int unsigned                    STACK_PAGES = stlb_pkg::DEF_STACK_PAGES,
  parameter logic [stlb_pkg::ADDR_W-1:0]    STACK_TOP   = stlb_pkg::DEF_STACK_TOP
) (
  input  stlb_pkg::in_item_t   item,
  input  stlb_pkg::cfg_regs_t  regs,
  output stlb_pkg::xlate_res_t res
);
  import stlb_pkg::*;

  localparam logic [ADDR_W-1:0] STACK_BASE =
    STACK_TOP - (ADDR_W'(STACK_PAGES) << PAGE_SHIFT);

  logic [ADDR_W-1:0] page_addr;
  logic [ADDR_W-1:0] text_top;
  logic [ADDR_W-1:0] data_top;
  logic              hit_text;
  logic              hit_data;
  logic              hit_stack;
  logic [ADDR_W-1:0] vbase_sel;
  logic [ADDR_W-1:0] pbase_sel;
  logic [ADDR_W-1:0] paddr;

  assign page_addr = {item.fault_address[ADDR_W-1:PAGE_SHIFT], {PAGE_SHIFT{1'b0}}};

  // region ends wrap at 32 bits, so a wrapped end matches nothing
  assign text_top  = regs.text_vbase + {regs.text_pages, {PAGE_SHIFT{1'b0}}};
  assign data_top  = regs.data_vbase + {regs.data_pages, {PAGE_SHIFT{1'b0}}};
  assign hit_text  = (page_addr >= regs.text_vbase) && (page_addr < text_top);
  assign hit_data  = (page_addr >= regs.data_vbase) && (page_addr < data_top);
  assign hit_stack = (page_addr >= STACK_BASE) && (page_addr < STACK_TOP);

  always_comb begin
    if (hit_text) begin
      vbase_sel = regs.text_vbase;
      pbase_sel = regs.text_pbase;
    end else if (hit_data) begin
      vbase_sel = regs.data_vbase;
      pbase_sel = regs.data_pbase;
    end else begin
      vbase_sel = STACK_BASE;
      pbase_sel = regs.stack_pbase;
    end
  end

  assign paddr = page_addr - vbase_sel + pbase_sel;

  always_comb begin
    res = '0;
    res.status = ST_DONE;
    if (op_t'(item.operation) == OP_FLUSH) begin
      res.flush = item.space_present;
    end else if (kind_t'(item.fault_kind) == KIND_READONLY) begin
      res.status = ST_FAULT;
    end else if (kind_t'(item.fault_kind) == KIND_UNKNOWN) begin
      res.status = ST_BAD_KIND;
    end else if (!item.space_present) begin
      res.status = ST_FAULT;
    end else if (!(hit_text || hit_data || hit_stack)) begin
      res.status = ST_FAULT;
    end else begin
      res.install    = 1'b1;
      res.entry_high = page_addr;
      res.entry_low  = {paddr[ADDR_W-1:PAGE_SHIFT], {PAGE_SHIFT{1'b0}}};
      res.entry_low[ENTRY_VALID_BIT] = 1'b1;
      res.entry_low[ENTRY_DIRTY_BIT] = !(hit_text && regs.text_wp);
    end
  end

endmodule

`default_nettype wire

// File: sv/stlb_slots.sv
// ----------------------------------------------------------------------------
// stlb_slots
// Slot valid bits, first-free search and round-robin replacement pointer.
// ----------------------------------------------------------------------------
`default_nettype none

module stlb_slots #(
  parameter int unsigned TLB_SLOTS = stlb_pkg::DEF_TLB_SLOTS
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  stlb_pkg::slot_req_t  req,
  output stlb_pkg::slot_grant_t grant
);
  import stlb_pkg::*;

  localparam int unsigned SLOT_W = $clog2(TLB_SLOTS);

  logic [TLB_SLOTS-1:0] slot_valid_r;
  logic [TLB_SLOTS-1:0] slot_valid_nxt;
  logic [SLOT_W-1:0]    ptr_r;
  logic [SLOT_W-1:0]    ptr_nxt;
  logic [SLOT_W-1:0]    first_free;
  logic                 all_valid;
  logic [SLOT_W-1:0]    slot_sel;

  // lowest-numbered invalid slot
  always_comb begin
    first_free = '0;
    for (int i = TLB_SLOTS - 1; i >= 0; i--) begin
      if (!slot_valid_r[i]) begin
        first_free = SLOT_W'(i);
      end
    end
  end

  assign all_valid = &slot_valid_r;
  assign slot_sel  = all_valid ? ptr_r : first_free;

  always_comb begin
    slot_valid_nxt = slot_valid_r;
    ptr_nxt        = ptr_r;
    if (req.fire && req.flush) begin
      slot_valid_nxt = '0;
    end else if (req.fire && req.install) begin
      slot_valid_nxt[slot_sel] = 1'b1;
      if (all_valid) begin
        ptr_nxt = (ptr_r == SLOT_W'(TLB_SLOTS - 1)) ? '0 : ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_valid_r <= '0;
      ptr_r        <= '0;
    end else begin
      slot_valid_r <= slot_valid_nxt;
      ptr_r        <= ptr_nxt;
    end
  end

  assign grant.slot       = SLOT_IDX_W'(slot_sel);
  assign grant.by_pointer = all_valid;

endmodule

`default_nettype wire

// File: sv/segment_tlb_refill_core.sv
// ----------------------------------------------------------------------------
// segment_tlb_refill_core
// Each transaction is held in the input register, then in the result register.
// Throughput: one transaction per cycle while the result channel does not stall;
// the slot valid bits and pointer are read and updated between the input and result registers.
// Reset: clears slot valid bits, replacement pointer, config regs and valids.
// ----------------------------------------------------------------------------
`default_nettype none

module segment_tlb_refill_core #(
  parameter int unsigned                 TLB_SLOTS   = stlb_pkg::DEF_TLB_SLOTS,
  parameter int unsigned                 STACK_PAGES = stlb_pkg::DEF_STACK_PAGES,
  parameter logic [stlb_pkg::ADDR_W-1:0] STACK_TOP   = stlb_pkg::DEF_STACK_TOP
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input channel
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_operation,
  input  wire logic [1:0]  in_fault_kind,
  input  wire logic [31:0] in_fault_address,
  input  wire logic        in_space_present,
  // result channel
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       out_status,
  output logic [5:0]       out_slot_written,
  output logic [31:0]      out_entry_high,
  output logic [31:0]      out_entry_low,
  output logic             out_placed_by_pointer,
  // configuration
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);
  import stlb_pkg::*;

  cfg_regs_t   regs;
  in_item_t    item_r;
  in_item_t    item_nxt;
  logic        s1_valid_r;
  logic        s1_valid_nxt;
  xlate_res_t  res;
  slot_req_t   sreq;
  slot_grant_t grant;
  logic        load_in;
  logic        advance;

  logic                  out_valid_r;
  logic                  out_valid_nxt;
  status_t               out_status_r;
  status_t               out_status_nxt;
  logic [SLOT_IDX_W-1:0] out_slot_r;
  logic [SLOT_IDX_W-1:0] out_slot_nxt;
  logic [ADDR_W-1:0]     out_ehi_r;
  logic [ADDR_W-1:0]     out_ehi_nxt;
  logic [ADDR_W-1:0]     out_elo_r;
  logic [ADDR_W-1:0]     out_elo_nxt;
  logic                  out_ptr_r;
  logic                  out_ptr_nxt;

  assign cfg_ready = 1'b1;

  stlb_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .regs      (regs)
  );

  // the input stage moves on whenever the result register is free or draining
  assign advance  = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !advance;
  assign load_in  = in_valid && !in_stall;

  always_comb begin
    item_nxt     = item_r;
    s1_valid_nxt = s1_valid_r;
    if (load_in) begin
      item_nxt.operation     = in_operation;
      item_nxt.fault_kind    = in_fault_kind;
      item_nxt.fault_address = in_fault_address;
      item_nxt.space_present = in_space_present;
      s1_valid_nxt           = 1'b1;
    end else if (advance) begin
      s1_valid_nxt = 1'b0;
    end
  end

  stlb_xlate #(
    .STACK_PAGES (STACK_PAGES),
    .STACK_TOP   (STACK_TOP)
  ) u_xlate (
    .item (item_r),
    .regs (regs),
    .res  (res)
  );

  assign sreq.fire    = advance;
  assign sreq.install = res.install;
  assign sreq.flush   = res.flush;

  stlb_slots #(
    .TLB_SLOTS (TLB_SLOTS)
  ) u_slots (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (sreq),
    .grant (grant)
  );

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_slot_nxt   = out_slot_r;
    out_ehi_nxt    = out_ehi_r;
    out_elo_nxt    = out_elo_r;
    out_ptr_nxt    = out_ptr_r;
    if (advance) begin
      out_valid_nxt  = 1'b1;
      out_status_nxt = res.status;
      out_slot_nxt   = res.install ? grant.slot : '0;
      out_ehi_nxt    = res.entry_high;
      out_elo_nxt    = res.entry_low;
      out_ptr_nxt    = res.install && grant.by_pointer;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r       <= item_nxt;
    out_status_r <= out_status_nxt;
    out_slot_r   <= out_slot_nxt;
    out_ehi_r    <= out_ehi_nxt;
    out_elo_r    <= out_elo_nxt;
    out_ptr_r    <= out_ptr_nxt;
  end

  assign out_valid             = out_valid_r;
  assign out_status            = out_status_r;
  assign out_slot_written      = out_slot_r;
  assign out_entry_high        = out_ehi_r;
  assign out_entry_low         = out_elo_r;
  assign out_placed_by_pointer = out_ptr_r;

  // a failed (non-done) transaction carries no entry; flush results are done and not checked here
  a_no_entry_on_fault: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_status_r != ST_DONE) |->
      (out_elo_r == '0) && (out_ehi_r == '0) && (out_slot_r == '0) && !out_ptr_r)
    else $error("entry fields set on a non-done result");

  // any installed entry has its valid bit set
  a_entry_valid_bit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_elo_r != '0) |-> out_elo_r[ENTRY_VALID_BIT])
    else $error("installed entry without valid bit");

  // the input side only stalls when the input stage is held behind a stalled result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r && out_valid_r && out_stall)
    else $error("input stalled without a blocked result");

  // pointer placement only happens on a completed install
  a_ptr_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_ptr_r |-> (out_status_r == ST_DONE) && out_elo_r[ENTRY_VALID_BIT])
    else $error("pointer placement without an installed entry");

endmodule

`default_nettype wire
